FILE: rtl/core/sdm_pkg.sv
// Shared types and constants for the signed-division magic number generator.
package sdm_pkg;

    localparam int SDM_WORD_W  = 64;
    localparam int SDM_DIV_W   = 63;
    localparam int SDM_SHIFT_W = 6;
    localparam int SDM_CNT_W   = 7;

    localparam logic [SDM_CNT_W-1:0]   SDM_MAX_STEPS   = 7'd64;
    localparam logic [SDM_SHIFT_W-1:0] SDM_LAST_BIT    = 6'd63;
    localparam logic [SDM_DIV_W-1:0]   SDM_MIN_DIVISOR = 63'd2;
    localparam logic [SDM_WORD_W-1:0]  SDM_TWO_P63_M1  = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_D,
        ST_NC,
        ST_DIV_NC,
        ST_DELTA,
        ST_STEP_R1,
        ST_STEP_R2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic take;
    } t_core_cmd;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    typedef struct packed {
        logic [SDM_WORD_W-1:0]  q2;
        logic [SDM_SHIFT_W-1:0] shift;
        logic                   valid;
    } t_core_res;

endpackage

FILE: rtl/core/sdm_if.sv
// Valid/ready channel interfaces for divisor input and magic number result.
interface sdm_in_if import sdm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SDM_DIV_W-1:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

interface sdm_out_if import sdm_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SDM_WORD_W-1:0]  magic_multiplier;
    logic [SDM_SHIFT_W-1:0] post_shift;
    logic                   needs_add;
    logic                   valid_res;

    modport source (output valid, output magic_multiplier, output post_shift,
                    output needs_add, output valid_res, input ready);
    modport sink   (input valid, input magic_multiplier, input post_shift,
                    input needs_add, input valid_res, output ready);
endinterface

FILE: rtl/core/sdm_cmpsub.sv
// Shared 64-bit compare and conditional subtract step.
module sdm_cmpsub import sdm_pkg::*; (
    input  logic [SDM_WORD_W-1:0] i_a,
    input  logic [SDM_WORD_W-1:0] i_b,
    output logic                  o_ge,
    output logic [SDM_WORD_W-1:0] o_diff
);

    logic [SDM_WORD_W:0] sub;

    assign sub    = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~sub[SDM_WORD_W];
    assign o_diff = o_ge ? sub[SDM_WORD_W-1:0] : i_a;

endmodule

FILE: rtl/core/sdm_core.sv
// Sequencer and working registers of the magic number search.
module sdm_core import sdm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_core_cmd            i_cmd,
    input  logic [SDM_DIV_W-1:0] i_divisor,
    output t_core_stat           o_stat,
    output t_core_res            o_res
);

    t_state                 r_state, n_state;
    logic [SDM_DIV_W-1:0]   r_d, n_d;
    logic [SDM_WORD_W-1:0]  r_nc, n_nc;
    logic [SDM_WORD_W-1:0]  r_q1, n_q1;
    logic [SDM_WORD_W-1:0]  r_r1, n_r1;
    logic [SDM_WORD_W-1:0]  r_q2, n_q2;
    logic [SDM_WORD_W-1:0]  r_r2, n_r2;
    logic [SDM_WORD_W-1:0]  r_delta, n_delta;
    logic [SDM_CNT_W-1:0]   r_cnt, n_cnt;
    logic [SDM_SHIFT_W-1:0] r_shift, n_shift;
    logic                   r_valid, n_valid;

    logic [SDM_WORD_W-1:0] u_a, u_b, u_diff;
    logic                  u_ge;
    logic                  div_bit;
    logic                  keep_going;
    logic [SDM_WORD_W-1:0] delta_x2;
    logic [SDM_WORD_W-1:0] d_ext;

    sdm_cmpsub u_cmpsub (
        .i_a    (u_a),
        .i_b    (u_b),
        .o_ge   (u_ge),
        .o_diff (u_diff)
    );

    assign d_ext      = {1'b0, r_d};
    assign div_bit    = (r_cnt[SDM_SHIFT_W-1:0] == '0);
    assign delta_x2   = {r_delta[SDM_WORD_W-2:0], 1'b0};
    assign keep_going = (r_q1 < r_delta) || ((r_q1 == r_delta) && (r_r1 == '0));

    always_comb begin
        unique case (r_state)
            ST_DIV_D: begin
                u_a = {r_r2[SDM_WORD_W-2:0], div_bit};
                u_b = d_ext;
            end
            ST_NC: begin
                u_a = SDM_TWO_P63_M1;
                u_b = r_r2;
            end
            ST_DIV_NC: begin
                u_a = {r_r1[SDM_WORD_W-2:0], div_bit};
                u_b = r_nc;
            end
            ST_DELTA: begin
                u_a = d_ext;
                u_b = r_r2;
            end
            ST_STEP_R1: begin
                u_a = {r_r1[SDM_WORD_W-2:0], 1'b0};
                u_b = r_nc;
            end
            ST_STEP_R2: begin
                u_a = {r_r2[SDM_WORD_W-2:0], 1'b0};
                u_b = d_ext;
            end
            default: begin
                u_a = '0;
                u_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_nc    <= n_nc;
        r_q1    <= n_q1;
        r_r1    <= n_r1;
        r_q2    <= n_q2;
        r_r2    <= n_r2;
        r_delta <= n_delta;
        r_cnt   <= n_cnt;
        r_shift <= n_shift;
        r_valid <= n_valid;
    end

    always_comb begin
        n_state = r_state;
        n_d     = r_d;
        n_nc    = r_nc;
        n_q1    = r_q1;
        n_r1    = r_r1;
        n_q2    = r_q2;
        n_r2    = r_r2;
        n_delta = r_delta;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_valid = r_valid;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_d     = i_divisor;
                    n_q2    = '0;
                    n_r2    = '0;
                    n_cnt   = '0;
                    n_shift = '0;
                    if (i_divisor < SDM_MIN_DIVISOR) begin
                        n_valid = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_valid = 1'b1;
                        n_state = ST_DIV_D;
                    end
                end
            end
            ST_DIV_D: begin
                n_q2  = {r_q2[SDM_WORD_W-2:0], u_ge};
                n_r2  = u_diff;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[SDM_SHIFT_W-1:0] == SDM_LAST_BIT) begin
                    n_cnt   = '0;
                    n_state = ST_NC;
                end
            end
            ST_NC: begin
                n_nc    = u_diff;
                n_q1    = '0;
                n_r1    = '0;
                n_state = ST_DIV_NC;
            end
            ST_DIV_NC: begin
                n_q1  = {r_q1[SDM_WORD_W-2:0], u_ge};
                n_r1  = u_diff;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[SDM_SHIFT_W-1:0] == SDM_LAST_BIT) begin
                    n_cnt   = '0;
                    n_state = ST_DELTA;
                end
            end
            ST_DELTA: begin
                n_delta = u_diff;
                n_state = ST_STEP_R1;
            end
            ST_STEP_R1: begin
                // check the previous doubling before taking another one
                if ((r_cnt != '0) && (!keep_going || (r_cnt == SDM_MAX_STEPS))) begin
                    n_shift = r_cnt[SDM_SHIFT_W-1:0] - 1'b1;
                    n_state = ST_DONE;
                end else begin
                    n_q1    = {r_q1[SDM_WORD_W-2:0], u_ge};
                    n_r1    = u_diff;
                    n_state = ST_STEP_R2;
                end
            end
            ST_STEP_R2: begin
                n_q2    = {r_q2[SDM_WORD_W-2:0], u_ge};
                n_r2    = u_diff;
                n_delta = u_ge ? delta_x2 : (delta_x2 - d_ext);
                n_cnt   = r_cnt + 1'b1;
                n_state = ST_STEP_R1;
            end
            ST_DONE: begin
                if (i_cmd.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stat.idle  = (r_state == ST_IDLE);
    assign o_stat.done  = (r_state == ST_DONE);
    assign o_res.q2     = r_q2;
    assign o_res.shift  = r_shift;
    assign o_res.valid  = r_valid;

    a_r2_below_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_R1) |-> (r_r2 < d_ext))
        else $error("r2 not below divisor");

    a_r1_below_nc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_R1) |-> (r_r1 < r_nc))
        else $error("r1 not below nc");

    a_delta_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP_R1) |-> (r_delta == (d_ext - r_r2)))
        else $error("delta out of step with r2");

endmodule

FILE: rtl/core/signed_div_magic_number_gen_top.sv
// Top level of the signed-division magic number generator.
//
//  channel  | dir | payload                                                | handshake
//  i_in     | in  | divisor[62:0]                                          | valid/ready
//  o_out    | out | magic_multiplier[63:0] post_shift[5:0] needs_add valid_res | valid/ready
//
//  Divisor below two: straight from idle to done in the sequencer, then the result register.
//  Otherwise the sequencer forms 2^63/d, then nc, then 2^63/nc, then delta, then runs
//  doubling steps (1..64 steps, each in STEP_R1 then STEP_R2) plus a final check,
//  all through the single shared compare/subtract unit.
//  i_in.ready is high only while the sequencer is idle; a finished result
//  moves to the output register while it is empty or being drained.
//  Synchronous active-low reset returns to idle with no result pending.
module signed_div_magic_number_gen_top import sdm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdm_in_if.sink        i_in,
    sdm_out_if.source     o_out
);

    t_core_cmd  core_cmd;
    t_core_stat core_stat;
    t_core_res  core_res;

    logic                   r_out_valid;
    logic [SDM_WORD_W-1:0]  r_mult;
    logic [SDM_SHIFT_W-1:0] r_shift;
    logic                   r_valid_res;
    logic                   load;

    assign load           = core_stat.done && (!r_out_valid || o_out.ready);
    assign core_cmd.start = i_in.valid && core_stat.idle;
    assign core_cmd.take  = load;
    assign i_in.ready     = core_stat.idle;

    sdm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (core_cmd),
        .i_divisor (i_in.divisor),
        .o_stat    (core_stat),
        .o_res     (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_mult      <= core_res.valid ? (core_res.q2 + 1'b1) : '0;
            r_shift     <= core_res.valid ? core_res.shift : '0;
            r_valid_res <= core_res.valid;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.magic_multiplier = r_mult;
    assign o_out.post_shift       = r_shift;
    assign o_out.needs_add        = r_mult[SDM_WORD_W-1];
    assign o_out.valid_res        = r_valid_res;

endmodule

FILE: tb/sv/signed_div_magic_number_gen_top_tb.sv
// Testbench for the signed-division magic number generator: directed and random divisors.
module signed_div_magic_number_gen_top_tb import sdm_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1250;
    localparam int CALM_TAIL    = 120;
    localparam int DRAIN_CYCLES = 300;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic [SDM_DIV_W-1:0]   divisor;
        logic [SDM_WORD_W-1:0]  mult;
        logic [SDM_SHIFT_W-1:0] shift;
        logic                   add;
        logic                   ok;
    } t_magic;

    typedef struct packed {
        logic [SDM_DIV_W-1:0]   divisor;
        logic                   fixed_exp;
        logic [SDM_WORD_W-1:0]  mult;
        logic [SDM_SHIFT_W-1:0] shift;
        logic                   add;
        logic                   ok;
    } t_dir_row;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatches;

    t_magic pending_magic[$];

    sdm_in_if  in_ch();
    sdm_out_if out_ch();

    signed_div_magic_number_gen_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // divisors below two and divisor 3 have fixed, well-known answers
    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{63'd0,                      1'b1, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd1,                      1'b1, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd2,                      1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd3,                      1'b1, 64'h5555_5555_5555_5556, 6'd0, 1'b0, 1'b1},
        '{63'd5,                      1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd6,                      1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd7,                      1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd8,                      1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd10,                     1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd100,                    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd641,                    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'd1000000007,             1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h0000_0000_8000_0000,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h0000_0001_0000_0001,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h3FFF_FFFF_FFFF_FFFF,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h4000_0000_0000_0000,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h4000_0000_0000_0001,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h7FFF_FFFF_FFFF_FFFE,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h7FFF_FFFF_FFFF_FFFF,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h2AAA_AAAA_AAAA_AAAA,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h5555_5555_5555_5555,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0},
        '{63'h7FFF_FFFF_0000_0001,    1'b0, 64'd0, 6'd0, 1'b0, 1'b0}
    };

    function automatic t_magic calc_magic(input logic [SDM_DIV_W-1:0] divisor);
        t_magic m;
        logic [SDM_WORD_W-1:0] d, top, nc, q1, r1, q2, r2, delta;
        int p;
        int sh;
        m = '0;
        m.divisor = divisor;
        d = {1'b0, divisor};
        top = SDM_TWO_P63_M1 + 64'd1;
        if (d < 64'd2) return m;
        nc = top - 64'd1 - (top % d);
        q1 = top / nc;
        r1 = top - q1 * nc;
        q2 = top / d;
        r2 = top - q2 * d;
        p = 63;
        for (int step = 0; step < 64; step++) begin
            p++;
            q1 = q1 << 1;
            r1 = r1 << 1;
            if (r1 >= nc) begin
                q1 = q1 + 64'd1;
                r1 = r1 - nc;
            end
            q2 = q2 << 1;
            r2 = r2 << 1;
            if (r2 >= d) begin
                q2 = q2 + 64'd1;
                r2 = r2 - d;
            end
            delta = d - r2;
            if (!(q1 < delta || (q1 == delta && r1 == 64'd0))) break;
        end
        sh = p - 64;
        m.mult  = q2 + 64'd1;
        m.shift = sh[SDM_SHIFT_W-1:0];
        m.add   = m.mult[SDM_WORD_W-1];
        m.ok    = 1'b1;
        return m;
    endfunction

    function automatic logic [SDM_DIV_W-1:0] pick_divisor();
        logic [63:0]          raw;
        logic [SDM_DIV_W-1:0] v;
        int kind;
        int width;
        raw = {$urandom, $urandom};
        v = raw[SDM_DIV_W-1:0];
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            v = SDM_DIV_W'($urandom_range(0, 1));
        end else if (kind < 20) begin
            width = $urandom_range(1, 62);
            v = 63'd1 << width;
            case ($urandom_range(0, 2))
                0: v = v - 63'd1;
                1: v = v + 63'd1;
                default: ;
            endcase
        end else if (kind < 75) begin
            width = $urandom_range(2, 63);
            v = v & ((63'd1 << width) - 63'd1);
            v[width-1] = 1'b1;
        end
        return v;
    endfunction

    task automatic send_divisor(input t_magic want, input bit may_idle);
        in_ch.valid   <= 1'b1;
        in_ch.divisor <= want.divisor;
        do @(posedge clk); while (!in_ch.ready);
        pending_magic = {pending_magic, want};
        if (may_idle && $urandom_range(0, 2) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #25_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // result receiver: ready in random bursts, steady once calm
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end else begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        t_magic want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_magic.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected transfer: M=%h S=%0d add=%b ok=%b",
                             out_ch.magic_multiplier, out_ch.post_shift,
                             out_ch.needs_add, out_ch.valid_res);
                mismatches++;
            end else begin
                want = pending_magic.pop_front();
                if (out_ch.magic_multiplier !== want.mult || out_ch.post_shift !== want.shift ||
                    out_ch.needs_add !== want.add || out_ch.valid_res !== want.ok) begin
                    if (mismatches < 10)
                        $display("d=%0d exp M=%h S=%0d add=%b ok=%b got M=%h S=%0d add=%b ok=%b",
                                 want.divisor, want.mult, want.shift, want.add, want.ok,
                                 out_ch.magic_multiplier, out_ch.post_shift,
                                 out_ch.needs_add, out_ch.valid_res);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_magic want;
        bit     may_idle;
        mismatches = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.divisor <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].fixed_exp) begin
                want.divisor = dir_rows[i].divisor;
                want.mult    = dir_rows[i].mult;
                want.shift   = dir_rows[i].shift;
                want.add     = dir_rows[i].add;
                want.ok      = dir_rows[i].ok;
            end else begin
                want = calc_magic(dir_rows[i].divisor);
            end
            send_divisor(want, 1'b1);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
            may_idle = !calm && ((i / 100) % 4 != 3);
            send_divisor(calc_magic(pick_divisor()), may_idle);
        end
        in_ch.valid <= 1'b0;

        wait (pending_magic.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
